>>> design/fixed_point_alu_core_macros.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms used by the ALU core.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_CORE_MACROS_SVH
`define FIXED_POINT_ALU_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Widths, opcodes, pipeline geometry and stage types of the Q24.8 ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;

    // Divider: one quotient bit per step, a fixed number of steps per stage
    localparam int DIV_BITS   = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD    = DIV_STAGES * DIV_STEPS;

    // Front stage, divider stages, rounding stage, output stage
    localparam int PIPE_DEPTH = DIV_STAGES + 3;
    localparam int LAST_STAGE = PIPE_DEPTH - 1;
    localparam int MUL_STAGE  = 2;

    localparam logic [DATA_WIDTH-1:0] FX_ONE = DATA_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        FUNC_ADD      = 4'd0,
        FUNC_SUB      = 4'd1,
        FUNC_MUL      = 4'd2,
        FUNC_DIV      = 4'd3,
        FUNC_GT       = 4'd4,
        FUNC_LT       = 4'd5,
        FUNC_GE       = 4'd6,
        FUNC_LE       = 4'd7,
        FUNC_EQ       = 4'd8,
        FUNC_NE       = 4'd9,
        FUNC_MIN      = 4'd10,
        FUNC_MAX      = 4'd11,
        FUNC_INC      = 4'd12,
        FUNC_DEC      = 4'd13,
        FUNC_TO_INT   = 4'd14,
        FUNC_FROM_INT = 4'd15
    } func_t;

    // Operand magnitudes and result sign for the multiplier and divider
    typedef struct packed {
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic                  neg;
    } oper_t;

    // Side-band item carried along the main pipeline
    typedef struct packed {
        func_t                 func;
        logic [DATA_WIDTH-1:0] res;
        logic                  cmp;
        logic                  dz;
    } side_t;

    // Restoring divider state between stages
    typedef struct packed {
        logic [DIV_PAD-1:0]    num;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] den;
        logic                  neg;
    } div_state_t;

endpackage

>>> design/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU core
// Signed Q24.8 ALU: add, sub, mul, div, comparisons, min, max, inc, dec and
// integer conversions, one result per item.
// ----------------------------------------------------------------------------
// The core takes one item per clock while s_ready is high. The pipeline
// depth (PIPE_DEPTH = DIV_STAGES + 3) is set by the divider:
// 40 restoring steps at 8 steps per stage give 5 stages, with one front stage
// for decode and operand magnitudes, one rounding stage and the output
// register. Every opcode takes the same path length, so results leave in the
// order items arrive. When m_ready is low and a result is waiting, the whole
// pipeline holds and s_ready drops; while the output stage is empty the
// pipeline keeps advancing even with m_ready low.
`timescale 1ns / 1ps
`include "fixed_point_alu_core_macros.svh"

module fixed_point_alu_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [3:0]                           s_func,
    input  logic signed [fpa_pkg::DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DATA_WIDTH-1:0] s_operand_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [fpa_pkg::DATA_WIDTH-1:0] m_result,
    output logic                                 m_compare_true,
    output logic                                 m_divide_by_zero
);
    import fpa_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] valid_reg;
    side_t                 side_reg  [PIPE_DEPTH];
    side_t                 side_next [PIPE_DEPTH];
    side_t                 side_front;
    oper_t                 oper_reg;
    oper_t                 oper_next;
    logic [DATA_WIDTH-1:0] mul_res;
    logic [DATA_WIDTH-1:0] div_res;

    func_t                 func_in;
    logic [DATA_WIDTH-1:0] a_u;
    logic [DATA_WIDTH-1:0] b_u;
    logic                  lt_ab;
    logic                  lt_ba;
    logic                  eq_ab;

    assign adv     = !valid_reg[LAST_STAGE] || m_ready;
    assign s_ready = adv;

    assign func_in = func_t'(s_func);
    assign a_u     = s_operand_a;
    assign b_u     = s_operand_b;
    assign lt_ab   = s_operand_a < s_operand_b;
    assign lt_ba   = s_operand_b < s_operand_a;
    assign eq_ab   = a_u == b_u;

    // Front stage: simple results, flags and magnitudes for mul and div
    always_comb begin
        logic cmp_hit;
        logic is_cmp;
        cmp_hit = 1'b0;
        is_cmp  = 1'b0;
        side_front.func = func_in;
        side_front.res  = '0;
        side_front.dz   = 1'b0;
        unique case (func_in)
            FUNC_ADD:      side_front.res = a_u + b_u;
            FUNC_SUB:      side_front.res = a_u - b_u;
            FUNC_MUL:      side_front.res = '0;
            FUNC_DIV:      side_front.dz  = (b_u == '0);
            FUNC_GT:       begin is_cmp = 1'b1; cmp_hit = lt_ba;  end
            FUNC_LT:       begin is_cmp = 1'b1; cmp_hit = lt_ab;  end
            FUNC_GE:       begin is_cmp = 1'b1; cmp_hit = !lt_ab; end
            FUNC_LE:       begin is_cmp = 1'b1; cmp_hit = !lt_ba; end
            FUNC_EQ:       begin is_cmp = 1'b1; cmp_hit = eq_ab;  end
            FUNC_NE:       begin is_cmp = 1'b1; cmp_hit = !eq_ab; end
            FUNC_MIN:      side_front.res = lt_ab ? a_u : b_u;
            FUNC_MAX:      side_front.res = lt_ba ? a_u : b_u;
            FUNC_INC:      side_front.res = a_u + DATA_WIDTH'(1);
            FUNC_DEC:      side_front.res = a_u - DATA_WIDTH'(1);
            FUNC_TO_INT:   side_front.res = DATA_WIDTH'(s_operand_a >>> FRAC_BITS);
            FUNC_FROM_INT: side_front.res = a_u << FRAC_BITS;
            default:       side_front.res = '0;
        endcase
        if (is_cmp) begin
            side_front.res = cmp_hit ? FX_ONE : '0;
        end
        side_front.cmp = cmp_hit;

        oper_next.mag_a = a_u[DATA_WIDTH-1] ? (~a_u + DATA_WIDTH'(1)) : a_u;
        oper_next.mag_b = b_u[DATA_WIDTH-1] ? (~b_u + DATA_WIDTH'(1)) : b_u;
        oper_next.neg   = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
    end

    // Later stages: pass the item on, merging mul and div results where they land
    always_comb begin
        side_next[0] = side_front;
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            side_next[k] = side_reg[k-1];
            if (k == MUL_STAGE && side_reg[k-1].func == FUNC_MUL) begin
                side_next[k].res = mul_res;
            end
            if (k == LAST_STAGE && side_reg[k-1].func == FUNC_DIV && !side_reg[k-1].dz) begin
                side_next[k].res = div_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                side_reg[k] <= side_next[k];
            end
            oper_reg <= oper_next;
        end
    end

    fpa_mul u_mul (
        .aclk    (aclk),
        .adv     (adv),
        .oper    (oper_reg),
        .product (mul_res)
    );

    fpa_div u_div (
        .aclk     (aclk),
        .adv      (adv),
        .oper     (oper_reg),
        .quotient (div_res)
    );

    assign m_valid          = valid_reg[LAST_STAGE];
    assign m_result         = side_reg[LAST_STAGE].res;
    assign m_compare_true   = side_reg[LAST_STAGE].cmp;
    assign m_divide_by_zero = side_reg[LAST_STAGE].dz;

    `FPA_ASSERT_IMP(a_cmp_is_one, aclk, aresetn, m_valid && m_compare_true,
        m_result == FX_ONE, "comparison hit without a result of one")
    `FPA_ASSERT_IMP(a_dz_is_zero, aclk, aresetn, m_valid && m_divide_by_zero,
        m_result == '0 && !m_compare_true, "divide by zero with non-zero result")
    `FPA_ASSERT_NXT(a_stall_holds, aclk, aresetn, !adv,
        $stable(valid_reg), "pipeline moved during a stall")
    `FPA_ASSERT_NXT(a_dz_flagged, aclk, aresetn,
        s_valid && s_ready && s_func == FUNC_DIV && s_operand_b == '0,
        valid_reg[0] && side_reg[0].dz, "zero divisor not flagged at entry")
    `FPA_ASSERT_IMP(a_flags_excl, aclk, aresetn, m_valid,
        !(m_compare_true && m_divide_by_zero), "compare and divide flags both set")

endmodule

>>> design/fpa_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Registered magnitude product, then scale down by the fraction bits and
// restore the sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_mul (
    input  logic                          aclk,
    input  logic                          adv,
    input  fpa_pkg::oper_t                oper,
    output logic [fpa_pkg::DATA_WIDTH-1:0] product
);
    import fpa_pkg::*;

    logic [2*DATA_WIDTH-1:0] prod_reg;
    logic                    neg_reg;
    logic [DATA_WIDTH-1:0]   scaled;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= (2*DATA_WIDTH)'(oper.mag_a) * (2*DATA_WIDTH)'(oper.mag_b);
            neg_reg  <= oper.neg;
        end
    end

    // Truncate toward zero on the magnitude, then wrap
    assign scaled  = prod_reg[FRAC_BITS +: DATA_WIDTH];
    assign product = neg_reg ? (~scaled + DATA_WIDTH'(1)) : scaled;

endmodule

>>> design/fpa_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Pipelined restoring division of |a| * 2^FRAC_BITS by |b|, a fixed number
// of quotient bits per stage, then round half away from zero and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div (
    input  logic                          aclk,
    input  logic                          adv,
    input  fpa_pkg::oper_t                oper,
    output logic [fpa_pkg::DATA_WIDTH-1:0] quotient
);
    import fpa_pkg::*;

    div_state_t            stg_init;
    div_state_t            stg_next [DIV_STAGES];
    div_state_t            stg_reg  [DIV_STAGES];
    logic [DATA_WIDTH-1:0] rnd_q_reg;
    logic                  rnd_bit_reg;
    logic                  rnd_neg_reg;
    logic                  rnd_bit_next;

    always_comb begin
        stg_init.num = DIV_PAD'({oper.mag_a, {FRAC_BITS{1'b0}}});
        stg_init.rem = '0;
        stg_init.quo = '0;
        stg_init.den = oper.mag_b;
        stg_init.neg = oper.neg;
    end

    // Each stage shifts in the next dividend bits; only the low quotient bits are kept
    always_comb begin
        div_state_t          cur;
        logic [DATA_WIDTH:0] trial;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                cur = stg_init;
            end else begin
                cur = stg_reg[k-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                trial   = {cur.rem, cur.num[DIV_PAD-1]};
                cur.num = {cur.num[DIV_PAD-2:0], 1'b0};
                if (trial >= {1'b0, cur.den}) begin
                    cur.rem = DATA_WIDTH'(trial - {1'b0, cur.den});
                    cur.quo = {cur.quo[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    cur.rem = trial[DATA_WIDTH-1:0];
                    cur.quo = {cur.quo[DATA_WIDTH-2:0], 1'b0};
                end
            end
            stg_next[k] = cur;
        end
    end

    assign rnd_bit_next = {stg_reg[DIV_STAGES-1].rem, 1'b0} >= {1'b0, stg_reg[DIV_STAGES-1].den};

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                stg_reg[k] <= stg_next[k];
            end
            rnd_q_reg   <= stg_reg[DIV_STAGES-1].quo;
            rnd_bit_reg <= rnd_bit_next;
            rnd_neg_reg <= stg_reg[DIV_STAGES-1].neg;
        end
    end

    // -(q + r) = ~q + 1 - r, so one adder serves both signs
    assign quotient = rnd_neg_reg ? (~rnd_q_reg + DATA_WIDTH'(!rnd_bit_reg))
                                  : (rnd_q_reg + DATA_WIDTH'(rnd_bit_reg));

endmodule
